### rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// shared types, register codes and defaults of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 4;

  localparam int RANGE_W    = 13;
  localparam int CM_W       = 9;
  localparam int TRIG_W     = 8;
  localparam int HOLD_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // 58 us per cm round trip; the divider works on half the value against 29
  localparam int HALF_US_PER_CM = 29;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_CM    = 3'd4;

  localparam logic [TRIG_W-1:0] TRIG_PULSE_RST = 8'd10;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST    = 17'd101000;
  localparam logic [CM_W-1:0]   MIN_CM_RST     = 9'd2;
  localparam logic [CM_W-1:0]   MAX_CM_RST     = 9'd400;
  localparam logic [CM_W-1:0]   NEAR_CM_RST    = 9'd5;

  typedef struct packed {
    logic [TRIG_W-1:0] trig_pulse_ticks;
    logic [HOLD_W-1:0] holdoff_ticks;
    logic [CM_W-1:0]   min_cm;
    logic [CM_W-1:0]   max_cm;
    logic [CM_W-1:0]   near_cm;
  } uer_cfg_t;

  // per-tick control that rides along the pipeline
  typedef struct packed {
    logic trig;
    logic fin;
  } uer_ctl_t;

endpackage

### rtl/core/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if
// valid/ready channels of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
interface uer_sample_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface uer_result_if;
  logic                        valid;
  logic                        ready;
  logic                        trig_level;
  logic                        result_valid;
  logic [uer_pkg::RANGE_W-1:0] range_sixteenths;
  logic                        near;

  modport source (output valid, output trig_level, output result_valid,
                  output range_sixteenths, output near, input ready);
  modport sink (input valid, input trig_level, input result_valid,
                input range_sixteenths, input near, output ready);
endinterface

### rtl/core/uer_seq.sv
// ----------------------------------------------------------------------------
// uer_seq
// trigger / echo / holdoff sequencer, one step per accepted tick
// ----------------------------------------------------------------------------
module uer_seq #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   echo_level,
  input  uer_pkg::uer_cfg_t      cfg,
  output uer_pkg::uer_ctl_t      ctl,
  output logic [COUNT_WIDTH-1:0] count
);

  typedef enum logic [2:0] {
    PH_LOW1 = 3'd0,
    PH_HIGH = 3'd1,
    PH_LOW2 = 3'd2,
    PH_WAIT = 3'd3,
    PH_MEAS = 3'd4,
    PH_HOLD = 3'd5
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] SAT = '1;

  phase_t                       phase, phase_next;
  logic [uer_pkg::HOLD_W-1:0]   phase_ticks, phase_ticks_next;
  logic [COUNT_WIDTH-1:0]       echo_ticks, echo_ticks_next;
  logic [uer_pkg::HOLD_W-1:0]   ticks_inc;
  logic                         trig_done;

  assign ticks_inc = phase_ticks + 1'b1;
  assign trig_done = ticks_inc >= uer_pkg::HOLD_W'(cfg.trig_pulse_ticks);
  assign count     = echo_ticks;

  always_comb begin
    phase_next       = phase;
    phase_ticks_next = phase_ticks;
    echo_ticks_next  = echo_ticks;
    ctl              = '0;
    unique case (phase)
      PH_HIGH: begin
        ctl.trig         = 1'b1;
        phase_ticks_next = trig_done ? '0 : ticks_inc;
        if (trig_done) phase_next = PH_LOW2;
      end
      PH_LOW2: begin
        phase_ticks_next = trig_done ? '0 : ticks_inc;
        if (trig_done) phase_next = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo_level) begin
          echo_ticks_next = COUNT_WIDTH'(1);
          phase_next      = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          if (echo_ticks != SAT) echo_ticks_next = echo_ticks + 1'b1;
        end else begin
          ctl.fin          = 1'b1;
          phase_ticks_next = '0;
          phase_next       = (cfg.holdoff_ticks == '0) ? PH_LOW1 : PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (ticks_inc >= cfg.holdoff_ticks) begin
          phase_next       = PH_LOW1;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      default: begin
        // first low phase, also the landing place of unused codes
        phase_ticks_next = trig_done ? '0 : ticks_inc;
        phase_next       = trig_done ? PH_HIGH : PH_LOW1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LOW1;
      phase_ticks <= '0;
      echo_ticks  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      phase_ticks <= phase_ticks_next;
      echo_ticks  <= echo_ticks_next;
    end
  end

endmodule

### rtl/core/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// two-stage divide of the scaled echo count by 58 (reciprocal multiply, fix-up)
// ----------------------------------------------------------------------------
module uer_div #(
  parameter int COUNT_WIDTH   = uer_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = uer_pkg::FRACTION_BITS_DEF,
  localparam int NW = COUNT_WIDTH + FRACTION_BITS,
  localparam int XW = NW - 1,
  localparam int QW = XW - 4
) (
  input  logic                   clk,
  input  logic                   en_mul,
  input  logic                   en_fix,
  input  logic [COUNT_WIDTH-1:0] count,
  output logic [QW-1:0]          quot
);

  // floor(2^XW / 29): the estimate is low by at most one for any x < 2^XW
  localparam longint unsigned RECIP_L =
    (64'd1 << XW) / 64'(uer_pkg::HALF_US_PER_CM);
  localparam logic [QW-1:0] RECIP = QW'(RECIP_L);

  logic [NW-1:0]    scaled;
  logic [XW-1:0]    half;
  logic [XW+QW-1:0] prod;
  logic [XW-1:0]    x_b;
  logic [QW-1:0]    q_est_b;
  logic [XW-1:0]    rem;

  // floor(n / 58) == floor(floor(n / 2) / 29)
  assign scaled = NW'(count) << FRACTION_BITS;
  assign half   = scaled[NW-1:1];
  assign prod   = (XW+QW)'(half) * (XW+QW)'(RECIP);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      x_b     <= half;
      q_est_b <= prod[XW+QW-1:XW];
    end
  end

  assign rem = x_b - XW'(q_est_b) * XW'(uer_pkg::HALF_US_PER_CM);

  always_ff @(posedge clk) begin
    if (en_fix) begin
      quot <= (rem >= XW'(uer_pkg::HALF_US_PER_CM)) ? q_est_b + 1'b1 : q_est_b;
    end
  end

endmodule

### rtl/core/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// pulse-echo distance meter: trigger sequencing, echo timing, distance in 1/16 cm
// ----------------------------------------------------------------------------
// path: an accepted tick passes the sequencer register, reciprocal multiply,
//   fix-up and clamp / output register, and back-pressure can hold it
// throughput: one tick per cycle while the result side keeps up; the
//   sequencer state is the only loop, the divide is pipelined behind it
// reset (rst, synchronous): first trigger low phase, counts, range and near
//   flag cleared, registers back to defaults, pipeline empty
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH   = uer_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = uer_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  uer_sample_if.sink                     sample,
  uer_result_if.source                   result,
  input  logic                           cfg_wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NW = COUNT_WIDTH + FRACTION_BITS;
  localparam int QW = NW - 5;
  localparam int LW = uer_pkg::CM_W + FRACTION_BITS;
  // clamp width covers both the quotient and the shifted limits
  localparam int DW = (QW > LW) ? QW : LW;

  // --------------------------------------------------------------------------
  // configuration registers: the user writes them only while the pipeline is drained; the block does not enforce it
  // --------------------------------------------------------------------------
  uer_pkg::uer_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trig_pulse_ticks <= uer_pkg::TRIG_PULSE_RST;
      cfg.holdoff_ticks    <= uer_pkg::HOLDOFF_RST;
      cfg.min_cm           <= uer_pkg::MIN_CM_RST;
      cfg.max_cm           <= uer_pkg::MAX_CM_RST;
      cfg.near_cm          <= uer_pkg::NEAR_CM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        uer_pkg::REG_TRIG_PULSE: cfg.trig_pulse_ticks <= uer_pkg::TRIG_W'(cfg_data);
        uer_pkg::REG_HOLDOFF:    cfg.holdoff_ticks    <= uer_pkg::HOLD_W'(cfg_data);
        uer_pkg::REG_MIN_CM:     cfg.min_cm           <= uer_pkg::CM_W'(cfg_data);
        uer_pkg::REG_MAX_CM:     cfg.max_cm           <= uer_pkg::CM_W'(cfg_data);
        uer_pkg::REG_NEAR_CM:    cfg.near_cm          <= uer_pkg::CM_W'(cfg_data);
        default: ; // indexes past the list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: a stage moves when the one after it is empty or moving,
  // so bubbles are squeezed out and a stalled result still lets ticks in while
  // any stage before the output register is empty
  logic vld_a, vld_b, vld_c, vld_o;
  logic rdy_a, rdy_b, rdy_c, rdy_o;
  logic accept;

  assign rdy_o        = !vld_o || result.ready;
  assign rdy_c        = !vld_c || rdy_o;
  assign rdy_b        = !vld_b || rdy_c;
  assign rdy_a        = !vld_a || rdy_b;
  assign sample.ready = rdy_a;
  assign accept       = sample.valid && sample.ready;

  // --------------------------------------------------------------------------
  // sequencer: state steps on every accepted transaction
  // --------------------------------------------------------------------------
  uer_pkg::uer_ctl_t      seq_ctl;
  logic [COUNT_WIDTH-1:0] seq_count;

  uer_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .echo_level (sample.echo_level),
    .cfg        (cfg),
    .ctl        (seq_ctl),
    .count      (seq_count)
  );

  // stage a holds the step outcome, b the quotient estimate, c the exact quotient
  uer_pkg::uer_ctl_t      ctl_a, ctl_b, ctl_c;
  logic [COUNT_WIDTH-1:0] count_a;
  logic [QW-1:0]          quot_c;
  logic                   adv_a, adv_b, adv_c, adv_o;

  assign adv_a = accept;
  assign adv_b = vld_a && rdy_b;
  assign adv_c = vld_b && rdy_c;
  assign adv_o = vld_c && rdy_o;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      ctl_a   <= seq_ctl;
      count_a <= seq_count;
    end
    if (adv_b) ctl_b <= ctl_a;
    if (adv_c) ctl_c <= ctl_b;
  end

  uer_div #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk    (clk),
    .en_mul (adv_b),
    .en_fix (adv_c),
    .count  (count_a),
    .quot   (quot_c)
  );

  // --------------------------------------------------------------------------
  // clamp and near flag: max first, then min, so min wins when they cross
  // --------------------------------------------------------------------------
  logic [DW-1:0] lim_hi, lim_lo, lim_near;
  logic [DW-1:0] dist_hi, dist_clamp;

  assign lim_hi     = DW'(cfg.max_cm) << FRACTION_BITS;
  assign lim_lo     = DW'(cfg.min_cm) << FRACTION_BITS;
  assign lim_near   = DW'(cfg.near_cm) << FRACTION_BITS;
  assign dist_hi    = (DW'(quot_c) > lim_hi) ? lim_hi : DW'(quot_c);
  assign dist_clamp = (dist_hi < lim_lo) ? lim_lo : dist_hi;

  // --------------------------------------------------------------------------
  // valid bits and output register; range and near hold between measurements
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a                   <= 1'b0;
      vld_b                   <= 1'b0;
      vld_c                   <= 1'b0;
      vld_o                   <= 1'b0;
      result.range_sixteenths <= '0;
      result.near             <= 1'b0;
    end else begin
      if (rdy_a) vld_a <= accept;
      if (rdy_b) vld_b <= vld_a;
      if (rdy_c) vld_c <= vld_b;
      if (rdy_o) vld_o <= vld_c;
      if (adv_o && ctl_c.fin) begin
        result.range_sixteenths <= uer_pkg::RANGE_W'(dist_clamp);
        if (dist_clamp < lim_near) begin
          result.near <= 1'b1;
        end else if (dist_clamp > lim_near) begin
          result.near <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      result.trig_level   <= ctl_c.trig;
      result.result_valid <= ctl_c.fin;
    end
  end

  assign result.valid = vld_o;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // trigger high and measurement end belong to different phases
  a_trig_excl_fin: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.trig_level && result.result_valid))
    else $error("trigger and finished measurement in one transaction");

  // a full pipeline with a stalled output must refuse new ticks
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (vld_a && vld_b && vld_c && vld_o && !result.ready) |-> !sample.ready)
    else $error("tick taken while pipeline is full");

  // range only changes on a transaction that finishes a measurement
  a_range_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(adv_o && ctl_c.fin)) |-> $stable(result.range_sixteenths))
    else $error("range changed without a finished measurement");

endmodule

### tb/ultrasonic_echo_ranger_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// self-checking bench for the echo ranger: every tick transaction is
// predicted by a cycle-free model of the trigger / echo / hold-off sequencer
// and the distance clamp, and every result transaction is compared in order
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TICK_TARGET  = 1900;
  localparam int US_PER_CM    = 58;
  localparam int COUNT_W      = COUNT_WIDTH_DEF;
  localparam int CM_MAX_VAL   = (1 << CM_W) - 1;

  // first index past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_NEAR_CM + 3'd1;

  typedef enum logic [2:0] {
    TRIG_LOW1, TRIG_HIGH, TRIG_LOW2, ECHO_WAIT, ECHO_MEAS, HOLD_OFF
  } ranger_phase_t;

  typedef struct packed {
    logic               trig;
    logic               fresh;
    logic [RANGE_W-1:0] range_16ths;
    logic               near;
  } ranger_tick_t;

  // predicts each tick and keeps the expected results in order
  class echo_scoreboard;
    uer_cfg_t           regs;
    ranger_phase_t      phase;
    logic [HOLD_W-1:0]  phase_ticks;
    logic [COUNT_W-1:0] echo_ticks;
    logic [RANGE_W-1:0] last_range;
    logic               near_flag;
    ranger_tick_t       expected_q[$];
    int                 errors;

    function new();
      regs.trig_pulse_ticks = TRIG_PULSE_RST;
      regs.holdoff_ticks    = HOLDOFF_RST;
      regs.min_cm           = MIN_CM_RST;
      regs.max_cm           = MAX_CM_RST;
      regs.near_cm          = NEAR_CM_RST;
      phase       = TRIG_LOW1;
      phase_ticks = '0;
      echo_ticks  = '0;
      last_range  = '0;
      near_flag   = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TRIG_PULSE: regs.trig_pulse_ticks = data[TRIG_W-1:0];
        REG_HOLDOFF:    regs.holdoff_ticks    = data[HOLD_W-1:0];
        REG_MIN_CM:     regs.min_cm           = data[CM_W-1:0];
        REG_MAX_CM:     regs.max_cm           = data[CM_W-1:0];
        REG_NEAR_CM:    regs.near_cm          = data[CM_W-1:0];
        default: ;
      endcase
    endfunction

    function void step_trigger(ranger_phase_t next_phase);
      phase_ticks = phase_ticks + 1'b1;
      if (phase_ticks >= HOLD_W'(regs.trig_pulse_ticks)) begin
        phase       = next_phase;
        phase_ticks = '0;
      end
    endfunction

    // max clamp first, min clamp last; near flag holds on equality
    function void settle_range();
      int unsigned d, hi, lo, th;
      d  = (int'(echo_ticks) << FRACTION_BITS_DEF) / US_PER_CM;
      hi = int'(regs.max_cm) << FRACTION_BITS_DEF;
      lo = int'(regs.min_cm) << FRACTION_BITS_DEF;
      th = int'(regs.near_cm) << FRACTION_BITS_DEF;
      if (d > hi) d = hi;
      if (d < lo) d = lo;
      if (d < th) near_flag = 1'b1;
      else if (d > th) near_flag = 1'b0;
      last_range = d[RANGE_W-1:0];
    endfunction

    function void note_tick(logic echo);
      ranger_tick_t o;
      o = '0;
      case (phase)
        TRIG_HIGH: begin
          o.trig = 1'b1;
          step_trigger(TRIG_LOW2);
        end
        TRIG_LOW2: step_trigger(ECHO_WAIT);
        ECHO_WAIT: begin
          if (echo) begin
            echo_ticks = COUNT_W'(1);
            phase      = ECHO_MEAS;
          end
        end
        ECHO_MEAS: begin
          if (echo) begin
            if (echo_ticks != {COUNT_W{1'b1}}) echo_ticks = echo_ticks + 1'b1;
          end else begin
            settle_range();
            o.fresh     = 1'b1;
            phase_ticks = '0;
            phase       = (regs.holdoff_ticks == '0) ? TRIG_LOW1 : HOLD_OFF;
          end
        end
        HOLD_OFF: begin
          phase_ticks = phase_ticks + 1'b1;
          if (phase_ticks >= regs.holdoff_ticks) begin
            phase       = TRIG_LOW1;
            phase_ticks = '0;
          end
        end
        default: step_trigger(TRIG_HIGH);
      endcase
      o.range_16ths = last_range;
      o.near        = near_flag;
      expected_q.push_back(o);
    endfunction

    function void check_result(logic trig, logic fresh, logic [RANGE_W-1:0] rng, logic near);
      ranger_tick_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: trig=%0b valid=%0b range=%0d near=%0b",
                   trig, fresh, rng, near);
        return;
      end
      want = expected_q.pop_front();
      if (trig !== want.trig || fresh !== want.fresh ||
          rng !== want.range_16ths || near !== want.near) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp t=%0b v=%0b r=%0d n=%0b got t=%0b v=%0b r=%0d n=%0b",
                   want.trig, want.fresh, want.range_16ths, want.near,
                   trig, fresh, rng, near);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // while set, neither side inserts bubbles
  bit steady;
  // tick transactions taken so far
  int ticks_sent = 0;

  uer_sample_if sample_ch ();
  uer_result_if result_ch ();

  echo_scoreboard sb = new();

  ultrasonic_echo_ranger dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // backstop in case a handshake never completes
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("simulation failed");
    $finish;
  end

  // sink backpressure: a stall chance of 16 in 100 outside the steady window
  always @(negedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= 16);
  end

  // result monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.trig_level, result_ch.result_valid,
                      result_ch.range_sixteenths, result_ch.near);
  end

  // one tick transaction; the model advances once the tick is taken
  task automatic send_tick(input logic echo);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 16) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.echo_level <= echo;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_tick(echo);
    ticks_sent++;
  endtask

  // register write once every tick in flight has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one full measurement: noise through trigger / hold-off, a quiet wait,
  // an echo pulse of high_len ticks, then the falling tick that ends it
  task automatic run_echo(input int wait_low, input int high_len);
    while (sb.phase != ECHO_WAIT) send_tick(1'($urandom_range(1)));
    repeat (wait_low) send_tick(1'b0);
    repeat (high_len) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // centimetre register value: mostly in [lo, hi], sometimes anything
  function automatic logic [CFG_DATA_W-1:0] pick_cm(input int lo, input int hi);
    case ($urandom_range(7))
      0:       return CFG_DATA_W'($urandom);
      1:       return CFG_DATA_W'($urandom_range(CM_MAX_VAL));
      default: return CFG_DATA_W'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic shuffle_regs();
    write_reg(REG_TRIG_PULSE, ($urandom_range(9) == 0) ?
              CFG_DATA_W'($urandom_range(255)) : CFG_DATA_W'($urandom_range(8)));
    case ($urandom_range(9))
      0:       write_reg(REG_HOLDOFF, CFG_DATA_W'($urandom_range(2000)));
      1, 2:    write_reg(REG_HOLDOFF, '0);
      default: write_reg(REG_HOLDOFF, CFG_DATA_W'($urandom_range(40)));
    endcase
    write_reg(REG_MIN_CM, pick_cm(0, 3));
    write_reg(REG_MAX_CM, pick_cm(1, 30));
    write_reg(REG_NEAR_CM, pick_cm(0, 30));
    // a stray write past the register file
    if ($urandom_range(5) == 0)
      write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
  endtask

  initial begin
    int wait_low;
    int high_len;

    rst                  = 1'b1;
    steady               = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.echo_level = 1'b0;
    result_ch.ready      = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---

    // reset settings, shortest echo: zero distance lifted to the 2 cm floor
    run_echo(3, 1);
    // inside the long default hold-off: widest value, then zero mid-phase
    repeat (4) send_tick(1'($urandom_range(1)));
    write_reg(REG_HOLDOFF, CFG_DATA_W'((1 << HOLD_W) - 1));
    repeat (4) send_tick(1'($urandom_range(1)));
    write_reg(REG_HOLDOFF, '0);

    // zero trigger length acts as one tick per phase; no floor
    write_reg(REG_TRIG_PULSE, '0);
    write_reg(REG_MIN_CM, '0);
    run_echo(0, 1);
    // 1 cm threshold: 58 ticks land exactly on it and the flag holds,
    // 80 ticks are above it and clear it, then equal keeps it cleared
    write_reg(REG_NEAR_CM, CFG_DATA_W'(1));
    run_echo(2, 58);
    run_echo(0, 80);
    run_echo(1, 58);

    // ceiling of 1 cm, clamped value equal to the threshold
    write_reg(REG_MAX_CM, CFG_DATA_W'(1));
    run_echo(0, 100);
    // floor above ceiling: the floor wins
    write_reg(REG_MIN_CM, CFG_DATA_W'(CM_MAX_VAL));
    run_echo(0, 5);

    // widest ceiling, 400 cm threshold, single-tick trigger phases
    write_reg(REG_TRIG_PULSE, CFG_DATA_W'(1));
    write_reg(REG_MIN_CM, '0);
    write_reg(REG_MAX_CM, CFG_DATA_W'(CM_MAX_VAL));
    write_reg(REG_NEAR_CM, CFG_DATA_W'(400));
    run_echo(0, 300);

    // zero threshold: equal holds, above clears
    write_reg(REG_NEAR_CM, '0);
    run_echo(0, 1);
    run_echo(0, 100);

    // writes past the register file change nothing
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_LO + 3'd1, '1);
    write_reg(REG_UNUSED_LO + 3'd2, '1);
    run_echo(0, 50);

    // --- random part ---
    shuffle_regs();
    while (ticks_sent < TICK_TARGET) begin
      // now and then stop at an arbitrary phase and retune the registers
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(20)) send_tick(1'($urandom_range(1)));
        shuffle_regs();
      end
      steady   = (ticks_sent >= 1200 && ticks_sent < 1600);
      wait_low = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(10);
      case ($urandom_range(19))
        0:           high_len = $urandom_range(1000, 201);
        1, 2, 3:     high_len = $urandom_range(200, 25);
        default:     high_len = $urandom_range(24, 1);
      endcase
      run_echo(wait_low, high_len);
    end
    steady = 1'b0;

    // drain, then give the pipeline time to show any stray result
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
